/* src/tbb_pkg.sv */
// Shared widths, register codes and types for the transformed bounding box block.
`timescale 1ns / 1ps
package tbb_pkg;

	localparam int COORD_W   = 32;
	localparam int COEF_W    = 16;
	localparam int COEF_FRAC = COEF_W - 4;
	localparam int AXES      = 3;
	localparam int ROW_W     = AXES * COEF_W;
	localparam int CFG_DATA_W = (ROW_W > COORD_W) ? ROW_W : COORD_W;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_Z   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z = 3'd5;

	// identity rows: 1.0 on the matching input
	localparam logic [ROW_W-1:0] ROW_X_RST = ROW_W'(1) << (COEF_FRAC + 2 * COEF_W);
	localparam logic [ROW_W-1:0] ROW_Y_RST = ROW_W'(1) << (COEF_FRAC + COEF_W);
	localparam logic [ROW_W-1:0] ROW_Z_RST = ROW_W'(1) << COEF_FRAC;

	localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
	localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W - 1){1'b0}}};

	// transform datapath
	localparam int PROD_W = COORD_W + COEF_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int TOT_W  = SUM_W - COEF_FRAC + 1;

	// radius datapath
	localparam int SQ_W      = 2 * COORD_W + 2;
	localparam int ROOT_W    = SQ_W / 2;
	localparam int REM_W     = ROOT_W + 3;
	localparam int ROOT_CNT_W = $clog2(ROOT_W);

	localparam int QUEUE_AW    = 2;
	localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

	typedef struct packed {
		logic [AXES-1:0][ROW_W-1:0]   row;
		logic [AXES-1:0][COORD_W-1:0] shift;
	} cfg_t;

	typedef struct packed {
		logic                         last;
		logic [AXES-1:0][COORD_W-1:0] pt;
	} vtx_t;

	typedef struct packed {
		logic [AXES-1:0][COORD_W-1:0] mn;
		logic [AXES-1:0][COORD_W-1:0] mx;
		logic [AXES-1:0][COORD_W-1:0] ctr;
		logic [COORD_W-1:0]           radius;
	} res_t;

endpackage

/* src/tbb_front.sv */
// Front end: accepts vertices and applies the affine transform in a two-stage pipeline.
`timescale 1ns / 1ps
module tbb_front import tbb_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cfg_t                         cfg,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [AXES-1:0][COORD_W-1:0] pos,
	input  logic                         last,
	output logic                         push,
	output vtx_t                         push_data,
	input  logic                         q_full
);

	localparam logic signed [SUM_W-1:0] ROUND = SUM_W'(1) << (COEF_FRAC - 1);

	logic                       advance;
	logic                       v_s1, v_s2;
	logic                       last_s1, last_s2;
	logic signed [PROD_W-1:0]   prod_s1 [AXES][AXES];
	logic [AXES-1:0][COORD_W-1:0] m_s2;
	logic signed [SUM_W-1:0]    sum_c [AXES];
	logic signed [SUM_W-1:0]    shr_c [AXES];
	logic signed [TOT_W-1:0]    tot_c [AXES];
	logic [AXES-1:0][COORD_W-1:0] sat_c;

	// hold the whole pipe while the queue cannot take the finished vertex
	assign advance  = !(v_s2 && q_full);
	assign in_stall = !advance;
	assign push     = v_s2 && !q_full;
	assign push_data.last = last_s2;
	assign push_data.pt   = m_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			last_s1 <= last;
			for (int a = 0; a < AXES; a++) begin
				for (int k = 0; k < AXES; k++) begin
					prod_s1[a][k] <= $signed(pos[k])
						* $signed(cfg.row[a][(AXES - 1 - k) * COEF_W +: COEF_W]);
				end
			end
			last_s2 <= last_s1;
			m_s2    <= sat_c;
		end
	end

	// sum, round half up to Q16.16, translate, saturate
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			sum_c[a] = SUM_W'(prod_s1[a][0]) + SUM_W'(prod_s1[a][1])
				+ SUM_W'(prod_s1[a][2]) + ROUND;
			shr_c[a] = sum_c[a] >>> COEF_FRAC;
			tot_c[a] = $signed(shr_c[a][TOT_W-1:0]) + TOT_W'($signed(cfg.shift[a]));
			if (tot_c[a] > TOT_W'(COORD_MAX)) begin
				sat_c[a] = COORD_MAX;
			end else if (tot_c[a] < TOT_W'(COORD_MIN)) begin
				sat_c[a] = COORD_MIN;
			end else begin
				sat_c[a] = tot_c[a][COORD_W-1:0];
			end
		end
	end

endmodule

/* src/tbb_queue.sv */
// Short queue of transformed vertices between the front end and the box unit.
`timescale 1ns / 1ps
module tbb_queue import tbb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  vtx_t push_data,
	output logic full,
	input  logic pop,
	output logic q_valid,
	output vtx_t pop_data
);

	vtx_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q, rd_q;
	logic [QUEUE_AW:0]   cnt_q;

	assign full     = cnt_q == (QUEUE_AW + 1)'(QUEUE_DEPTH);
	assign q_valid  = cnt_q != '0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

/* src/tbb_back.sv */
// Back end: running box, squared diagonal, bit-serial square root and result register.
`timescale 1ns / 1ps
module tbb_back import tbb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  vtx_t pop_data,
	output logic pop,
	output logic out_valid,
	input  logic out_stall,
	output res_t res
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SQ   = 2'd1;
	localparam logic [1:0] ST_ROOT = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]                state_q;
	logic [1:0]                sq_cnt_q;
	logic [ROOT_CNT_W-1:0]     root_cnt_q;
	logic signed [COORD_W-1:0] box_min_q [AXES];
	logic signed [COORD_W-1:0] box_max_q [AXES];
	logic [2*COORD_W-1:0]      prod_q;
	logic [SQ_W-1:0]           acc_q;
	logic [REM_W-1:0]          rem_q;
	logic [ROOT_W-1:0]         root_q;
	logic                      out_valid_q;
	res_t                      res_q;

	logic [COORD_W-1:0]        d_c;
	logic [REM_W-1:0]          rem_n, trial;
	logic                      load;
	logic signed [COORD_W:0]   mid_c [AXES];

	assign pop       = (state_q == ST_IDLE) && q_valid;
	assign load      = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign res       = res_q;

	always_comb begin
		case (sq_cnt_q)
			2'd0:    d_c = COORD_W'(box_max_q[0] - box_min_q[0]);
			2'd1:    d_c = COORD_W'(box_max_q[1] - box_min_q[1]);
			2'd2:    d_c = COORD_W'(box_max_q[2] - box_min_q[2]);
			default: d_c = '0;
		endcase
	end

	// one root bit per cycle: bring down two radicand bits, try 4*root+1
	assign rem_n = {rem_q[REM_W-3:0], acc_q[SQ_W-1:SQ_W-2]};
	assign trial = {1'b0, root_q, 2'b01};

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			mid_c[a] = (COORD_W + 1)'(box_min_q[a]) + (COORD_W + 1)'(box_max_q[a]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sq_cnt_q    <= '0;
			root_cnt_q  <= '0;
			out_valid_q <= 1'b0;
			for (int a = 0; a < AXES; a++) begin
				box_min_q[a] <= COORD_MAX;
				box_max_q[a] <= COORD_MIN;
			end
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						for (int a = 0; a < AXES; a++) begin
							if ($signed(pop_data.pt[a]) < box_min_q[a]) begin
								box_min_q[a] <= $signed(pop_data.pt[a]);
							end
							if ($signed(pop_data.pt[a]) > box_max_q[a]) begin
								box_max_q[a] <= $signed(pop_data.pt[a]);
							end
						end
						if (pop_data.last) begin
							state_q  <= ST_SQ;
							sq_cnt_q <= '0;
						end
					end
				end
				ST_SQ: begin
					sq_cnt_q <= sq_cnt_q + 1'b1;
					if (sq_cnt_q == 2'd3) begin
						state_q    <= ST_ROOT;
						root_cnt_q <= '0;
					end
				end
				ST_ROOT: begin
					root_cnt_q <= root_cnt_q + 1'b1;
					if (root_cnt_q == ROOT_CNT_W'(ROOT_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load) begin
						state_q <= ST_IDLE;
						// re-arm for the next mesh
						for (int a = 0; a < AXES; a++) begin
							box_min_q[a] <= COORD_MAX;
							box_max_q[a] <= COORD_MIN;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				acc_q  <= '0;
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_SQ: begin
				prod_q <= d_c * d_c;
				if (sq_cnt_q != 2'd0) begin
					acc_q <= acc_q + SQ_W'(prod_q);
				end
			end
			ST_ROOT: begin
				acc_q <= acc_q << 2;
				if (rem_n >= trial) begin
					rem_q  <= rem_n - trial;
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_n;
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
			end
			ST_DONE: begin
				if (load) begin
					for (int a = 0; a < AXES; a++) begin
						res_q.mn[a]  <= box_min_q[a];
						res_q.mx[a]  <= box_max_q[a];
						res_q.ctr[a] <= mid_c[a][COORD_W:1];
					end
					// half the root always fits the output width
					res_q.radius <= root_q[ROOT_W-1:1];
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

endmodule

/* src/transformed_bounding_box.sv */
// Top level: configuration registers, front end, vertex queue and box/radius back end.
//
// Vertices enter on in_valid/in_stall with pos_x/pos_y/pos_z (signed Q16.16) and
// last_vertex. Each is mapped through the configured 3x3 Q4.12 matrix plus a
// Q16.16 translation and folded into the running per-axis min/max. A transfer
// with last_vertex set closes the mesh: one result (box corners, centre and
// radius) is shown on out_valid/out_stall, and the box re-arms.
// Throughput: one vertex per cycle for vertices not marked last, while in_stall
// is low; the front end is a two-stage multiply/round pipeline feeding a
// four-entry queue. A last vertex occupies the back end for the squared
// diagonal on one shared 32x32 multiplier and for the bit-serial square root,
// one root bit per cycle. Vertices of the next mesh keep entering until the
// queue fills, then in_stall rises.
// A last vertex passes the two front-end stages and the queue; its result then
// follows the squared-diagonal and root states before out_valid rises.
// The result sits in an output register; while out_stall holds it, the back end
// keeps folding the next mesh and waits only once that mesh's result is ready.
// Reset (arst_n low) loads identity rows, zero translation, an empty box and
// an empty queue. The user must make configuration writes on cfg_we/cfg_index/cfg_data
// only while the block is idle; the block does not enforce it. Unknown indexes are ignored.
`timescale 1ns / 1ps
module transformed_bounding_box import tbb_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [COORD_W-1:0]  pos_x,
	input  logic signed [COORD_W-1:0]  pos_y,
	input  logic signed [COORD_W-1:0]  pos_z,
	input  logic                       last_vertex,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [COORD_W-1:0]  min_x,
	output logic signed [COORD_W-1:0]  min_y,
	output logic signed [COORD_W-1:0]  min_z,
	output logic signed [COORD_W-1:0]  max_x,
	output logic signed [COORD_W-1:0]  max_y,
	output logic signed [COORD_W-1:0]  max_z,
	output logic signed [COORD_W-1:0]  center_x,
	output logic signed [COORD_W-1:0]  center_y,
	output logic signed [COORD_W-1:0]  center_z,
	output logic [COORD_W-1:0]         radius
);

	cfg_t                         cfg_q;
	logic [AXES-1:0][COORD_W-1:0] pos;
	logic                         push, q_full, pop, q_valid;
	vtx_t                         push_data, pop_data;
	res_t                         res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row[0]   <= ROW_X_RST;
			cfg_q.row[1]   <= ROW_Y_RST;
			cfg_q.row[2]   <= ROW_Z_RST;
			cfg_q.shift[0] <= '0;
			cfg_q.shift[1] <= '0;
			cfg_q.shift[2] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW_X:   cfg_q.row[0]   <= cfg_data[ROW_W-1:0];
				REG_ROW_Y:   cfg_q.row[1]   <= cfg_data[ROW_W-1:0];
				REG_ROW_Z:   cfg_q.row[2]   <= cfg_data[ROW_W-1:0];
				REG_SHIFT_X: cfg_q.shift[0] <= cfg_data[COORD_W-1:0];
				REG_SHIFT_Y: cfg_q.shift[1] <= cfg_data[COORD_W-1:0];
				REG_SHIFT_Z: cfg_q.shift[2] <= cfg_data[COORD_W-1:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign pos[0] = pos_x;
	assign pos[1] = pos_y;
	assign pos[2] = pos_z;

	tbb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pos       (pos),
		.last      (last_vertex),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	tbb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.pop_data  (pop_data)
	);

	tbb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	assign min_x    = res.mn[0];
	assign min_y    = res.mn[1];
	assign min_z    = res.mn[2];
	assign max_x    = res.mx[0];
	assign max_y    = res.mx[1];
	assign max_z    = res.mx[2];
	assign center_x = res.ctr[0];
	assign center_y = res.ctr[1];
	assign center_z = res.ctr[2];
	assign radius   = res.radius;

	// the front end never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("vertex pushed into full queue");

	// the back end pops only what the queue holds
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("pop from empty queue");

	// input back-pressure comes only from a full queue
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> q_full)
		else $error("input stalled while queue has room");

	// a full queue with a waiting vertex keeps stalling until the back end pops
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_stall && !pop) |=> in_stall)
		else $error("stall released without a pop");

endmodule
